// File: design/ipv4_two_port_forwarder_macros.svh
// ----------------------------------------------------------------------------
// ipv4_two_port_forwarder_macros
// assertion macros used by the forwarder rtl
// ----------------------------------------------------------------------------
`ifndef IPV4_TWO_PORT_FORWARDER_MACROS_SVH
`define IPV4_TWO_PORT_FORWARDER_MACROS_SVH

// checked on every clock edge outside reset
`define IPV4F_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define IPV4F_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ipv4f_pkg.sv
// ----------------------------------------------------------------------------
// ipv4f_pkg
// types, constants and helper functions of the two-port ipv4 forwarder
// ----------------------------------------------------------------------------
package ipv4f_pkg;

	localparam int HW_W       = 16;
	localparam int MAC_W      = 48;
	localparam int ADDR_W     = 32;
	localparam int PFX_W      = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int WC_W       = 6;
	localparam int IHL_W      = 4;
	localparam int TTL_W      = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_R0_NETWORK  = 3'd0,
		CFG_R0_PREFIX   = 3'd1,
		CFG_R0_NEXT_MAC = 3'd2,
		CFG_P0_OWN_MAC  = 3'd3,
		CFG_R1_NETWORK  = 3'd4,
		CFG_R1_PREFIX   = 3'd5,
		CFG_R1_NEXT_MAC = 3'd6,
		CFG_P1_OWN_MAC  = 3'd7
	} cfg_index_t;

	// verdict codes
	typedef enum logic [3:0] {
		V_FORWARD     = 4'd0,
		V_SHORT       = 4'd1,
		V_LOOPED      = 4'd2,
		V_NOT_IPV4    = 4'd3,
		V_OWN_SOURCE  = 4'd4,
		V_BAD_HEADER  = 4'd5,
		V_NO_ROUTE    = 4'd6,
		V_SAME_PORT   = 4'd7,
		V_TTL_EXPIRED = 4'd8
	} verdict_t;

	// halfword positions in the frame
	localparam logic [WC_W-1:0] IDX_SRC_FIRST = 6'd3;
	localparam logic [WC_W-1:0] IDX_SRC_LAST  = 6'd5;
	localparam logic [WC_W-1:0] IDX_ETHERTYPE = 6'd6;
	localparam logic [WC_W-1:0] IDX_VER_IHL   = 6'd7;
	localparam logic [WC_W-1:0] IDX_TTL       = 6'd11;
	localparam logic [WC_W-1:0] IDX_CHECKSUM  = 6'd12;
	localparam logic [WC_W-1:0] IDX_DST_HI    = 6'd15;
	localparam logic [WC_W-1:0] IDX_DST_LO    = 6'd16;
	localparam logic [WC_W-1:0] LAST_BASE     = 6'd6;

	localparam logic [HW_W-1:0]  ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]       IP_VERSION4    = 4'd4;
	localparam logic [IHL_W-1:0] IHL_MIN        = 4'd5;
	localparam logic [TTL_W-1:0] TTL_MIN_FWD    = 8'd1;
	localparam logic [HW_W-1:0]  TTL_STEP       = 16'h0100;

	// register reset values
	localparam logic [ADDR_W-1:0] RST_R0_NETWORK  = 32'hC0A8_0100;
	localparam logic [PFX_W-1:0]  RST_R0_PREFIX   = 6'd24;
	localparam logic [MAC_W-1:0]  RST_R0_NEXT_MAC = 48'h0242_AC1E_0110;
	localparam logic [MAC_W-1:0]  RST_P0_OWN_MAC  = 48'h0;
	localparam logic [ADDR_W-1:0] RST_R1_NETWORK  = 32'hC0A8_0400;
	localparam logic [PFX_W-1:0]  RST_R1_PREFIX   = 6'd24;
	localparam logic [MAC_W-1:0]  RST_R1_NEXT_MAC = 48'h0242_AC1E_0410;
	localparam logic [MAC_W-1:0]  RST_P1_OWN_MAC  = 48'h0;

	typedef struct packed {
		logic [ADDR_W-1:0] r0_network;
		logic [PFX_W-1:0]  r0_prefix;
		logic [MAC_W-1:0]  r0_next_mac;
		logic [MAC_W-1:0]  p0_own_mac;
		logic [ADDR_W-1:0] r1_network;
		logic [PFX_W-1:0]  r1_prefix;
		logic [MAC_W-1:0]  r1_next_mac;
		logic [MAC_W-1:0]  p1_own_mac;
	} cfg_t;

	typedef struct packed {
		logic [HW_W-1:0] half_word;
		logic            frame_start;
		logic            frame_end;
		logic            arrival_port;
		logic            looped_back;
	} in_item_t;

	typedef struct packed {
		verdict_t         verdict;
		logic             out_port;
		logic [TTL_W-1:0] new_ttl;
		logic [HW_W-1:0]  new_checksum;
		logic [MAC_W-1:0] new_dest_mac;
		logic [MAC_W-1:0] new_source_mac;
	} result_t;

	// network mask of a prefix length, lengths above 32 count as 32
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] p);
		logic [ADDR_W-1:0] m;
		if (p == '0)
			m = '0;
		else if (p >= 6'd32)
			m = '1;
		else
			m = {ADDR_W{1'b1}} << (6'd32 - p);
		return m;
	endfunction

	// ones-complement add with end-around carry
	function automatic logic [HW_W-1:0] oc_add(input logic [HW_W-1:0] a,
		input logic [HW_W-1:0] b);
		logic [HW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[HW_W-1:0] + {{(HW_W-1){1'b0}}, s[HW_W]};
	endfunction

endpackage

// File: design/ipv4f_in_if.sv
// ----------------------------------------------------------------------------
// ipv4f_in_if
// halfword stream channel into the forwarder
// ----------------------------------------------------------------------------
interface ipv4f_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_word;
	logic        frame_start;
	logic        frame_end;
	logic        arrival_port;
	logic        looped_back;

	modport source (output valid, half_word, frame_start, frame_end, arrival_port,
		looped_back, input ready);
	modport sink (input valid, half_word, frame_start, frame_end, arrival_port,
		looped_back, output ready);
endinterface

// File: design/ipv4f_out_if.sv
// ----------------------------------------------------------------------------
// ipv4f_out_if
// verdict channel out of the forwarder
// ----------------------------------------------------------------------------
interface ipv4f_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  verdict;
	logic        out_port;
	logic [7:0]  new_ttl;
	logic [15:0] new_checksum;
	logic [47:0] new_dest_mac;
	logic [47:0] new_source_mac;

	modport source (output valid, verdict, out_port, new_ttl, new_checksum,
		new_dest_mac, new_source_mac, input ready);
	modport sink (input valid, verdict, out_port, new_ttl, new_checksum,
		new_dest_mac, new_source_mac, output ready);
endinterface

// File: design/ipv4f_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipv4f_cfg_regs
// route and mac configuration registers with a plain write port
// ----------------------------------------------------------------------------
module ipv4f_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [ipv4f_pkg::CFG_IDX_W-1:0]  index,
	input  logic [ipv4f_pkg::CFG_DATA_W-1:0] data,
	output ipv4f_pkg::cfg_t               cfg
);
	import ipv4f_pkg::*;

	cfg_t       cfg_q;
	cfg_index_t sel;

	assign sel = cfg_index_t'(index);
	assign cfg = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.r0_network  <= RST_R0_NETWORK;
			cfg_q.r0_prefix   <= RST_R0_PREFIX;
			cfg_q.r0_next_mac <= RST_R0_NEXT_MAC;
			cfg_q.p0_own_mac  <= RST_P0_OWN_MAC;
			cfg_q.r1_network  <= RST_R1_NETWORK;
			cfg_q.r1_prefix   <= RST_R1_PREFIX;
			cfg_q.r1_next_mac <= RST_R1_NEXT_MAC;
			cfg_q.p1_own_mac  <= RST_P1_OWN_MAC;
		end else if (we) begin
			unique case (sel)
				CFG_R0_NETWORK:  cfg_q.r0_network  <= data[ADDR_W-1:0];
				CFG_R0_PREFIX:   cfg_q.r0_prefix   <= data[PFX_W-1:0];
				CFG_R0_NEXT_MAC: cfg_q.r0_next_mac <= data[MAC_W-1:0];
				CFG_P0_OWN_MAC:  cfg_q.p0_own_mac  <= data[MAC_W-1:0];
				CFG_R1_NETWORK:  cfg_q.r1_network  <= data[ADDR_W-1:0];
				CFG_R1_PREFIX:   cfg_q.r1_prefix   <= data[PFX_W-1:0];
				CFG_R1_NEXT_MAC: cfg_q.r1_next_mac <= data[MAC_W-1:0];
				CFG_P1_OWN_MAC:  cfg_q.p1_own_mac  <= data[MAC_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end
endmodule

// File: design/ipv4f_frame_proc.sv
// ----------------------------------------------------------------------------
// ipv4f_frame_proc
// per-frame header state and verdict logic, one halfword per step
// ----------------------------------------------------------------------------
module ipv4f_frame_proc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ipv4f_pkg::in_item_t item,
	input  ipv4f_pkg::cfg_t     cfg,
	output logic                emit,
	output ipv4f_pkg::result_t  res
);
	import ipv4f_pkg::*;

	// frame state
	logic [WC_W-1:0]   wc_q, wc_e, wc_n;
	logic [IHL_W-1:0]  ihl_q, ihl_e, ihl_n;
	logic [ADDR_W-1:0] dst_q, dst_e, dst_n;
	logic [MAC_W-1:0]  smac_q, smac_e, smac_n;
	logic              ipv4_q, ipv4_e, ipv4_n;
	logic              ver_q, ver_e, ver_n;
	logic [TTL_W-1:0]  ttl_q, ttl_e, ttl_n;
	logic [HW_W-1:0]   sum_q, sum_e, sum_n;
	logic              port_q, port_e;
	logic              loop_q, loop_e;
	logic              sent_q, sent_e, sent_n;
	logic              rport_q, rport_e, rport_n;

	logic [WC_W-1:0]   idx;
	logic [WC_W-1:0]   last;
	logic [HW_W-1:0]   add_val;
	logic [ADDR_W-1:0] m0, m1;
	logic              h0, h1;
	logic              fwd;
	verdict_t          verdict;

	// state as seen by this halfword, a frame start clears it and loads the port and loop flags
	always_comb begin
		if (item.frame_start) begin
			wc_e    = '0;
			ihl_e   = '0;
			dst_e   = '0;
			smac_e  = '0;
			ipv4_e  = 1'b0;
			ver_e   = 1'b0;
			ttl_e   = '0;
			sum_e   = '0;
			rport_e = 1'b0;
			port_e  = item.arrival_port;
			loop_e  = item.looped_back;
			sent_e  = 1'b0;
		end else begin
			wc_e    = wc_q;
			ihl_e   = ihl_q;
			dst_e   = dst_q;
			smac_e  = smac_q;
			ipv4_e  = ipv4_q;
			ver_e   = ver_q;
			ttl_e   = ttl_q;
			sum_e   = sum_q;
			rport_e = rport_q;
			port_e  = port_q;
			loop_e  = loop_q;
			sent_e  = sent_q;
		end
	end

	// route lookup on the updated destination
	assign m0 = prefix_mask(cfg.r0_prefix);
	assign m1 = prefix_mask(cfg.r1_prefix);
	assign h0 = (dst_n & m0) == cfg.r0_network;
	assign h1 = (dst_n & m1) == cfg.r1_network;

	assign idx     = wc_e;
	assign last    = LAST_BASE + {1'b0, ihl_n, 1'b0};
	assign add_val = (idx == IDX_TTL) ? (item.half_word - TTL_STEP) : item.half_word;

	// header capture, checksum and drop checks
	always_comb begin
		wc_n    = wc_e;
		ihl_n   = ihl_e;
		dst_n   = dst_e;
		smac_n  = smac_e;
		ipv4_n  = ipv4_e;
		ver_n   = ver_e;
		ttl_n   = ttl_e;
		sum_n   = sum_e;
		rport_n = rport_e;
		emit    = 1'b0;
		verdict = V_FORWARD;
		if (!sent_e) begin
			wc_n = wc_e + 6'd1;
			if (idx >= IDX_SRC_FIRST && idx <= IDX_SRC_LAST)
				smac_n = {smac_e[MAC_W-HW_W-1:0], item.half_word};
			else if (idx == IDX_ETHERTYPE)
				ipv4_n = item.half_word == ETHERTYPE_IPV4;
			else if (idx == IDX_VER_IHL) begin
				ver_n = item.half_word[15:12] == IP_VERSION4;
				ihl_n = item.half_word[11:8];
			end else if (idx == IDX_TTL)
				ttl_n = item.half_word[15:8];
			else if (idx == IDX_DST_HI || idx == IDX_DST_LO)
				dst_n = {dst_e[ADDR_W-HW_W-1:0], item.half_word};

			// checksum field itself is left out
			if (idx >= IDX_VER_IHL && idx != IDX_CHECKSUM && (idx <= IDX_DST_LO || idx <= last))
				sum_n = oc_add(sum_e, add_val);

			if (idx < IDX_DST_LO) begin
				if (item.frame_end) begin
					emit    = 1'b1;
					verdict = V_SHORT;
				end
			end else if (idx == IDX_DST_LO) begin
				emit = 1'b1;
				if (item.frame_end && ihl_n > IHL_MIN)
					verdict = V_SHORT;
				else if (loop_e)
					verdict = V_LOOPED;
				else if (!ipv4_n)
					verdict = V_NOT_IPV4;
				else if (smac_n == cfg.p0_own_mac || smac_n == cfg.p1_own_mac)
					verdict = V_OWN_SOURCE;
				else if (!ver_n || ihl_n < IHL_MIN)
					verdict = V_BAD_HEADER;
				else if (!h0 && !h1)
					verdict = V_NO_ROUTE;
				else begin
					// route 1 wins if only it matches or if it has the longer prefix, else route 0
					rport_n = h1 && (!h0 || m1 > m0);
					if (rport_n == port_e)
						verdict = V_SAME_PORT;
					else if (ttl_n <= TTL_MIN_FWD)
						verdict = V_TTL_EXPIRED;
					else if (ihl_n == IHL_MIN)
						verdict = V_FORWARD;
					else
						emit = 1'b0;
				end
			end else if (idx == last) begin
				emit    = 1'b1;
				verdict = V_FORWARD;
			end else if (item.frame_end) begin
				emit    = 1'b1;
				verdict = V_SHORT;
			end
		end
	end

	assign sent_n = sent_e | emit;

	// result fields, zero on a drop
	assign fwd                = verdict == V_FORWARD;
	assign res.verdict        = verdict;
	assign res.out_port       = fwd & rport_n;
	assign res.new_ttl        = fwd ? ttl_n - 8'd1 : '0;
	assign res.new_checksum   = fwd ? ~sum_n : '0;
	assign res.new_dest_mac   = !fwd ? '0 : (rport_n ? cfg.r1_next_mac : cfg.r0_next_mac);
	assign res.new_source_mac = !fwd ? '0 : (rport_n ? cfg.p1_own_mac : cfg.p0_own_mac);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q    <= '0;
			ihl_q   <= '0;
			dst_q   <= '0;
			smac_q  <= '0;
			ipv4_q  <= 1'b0;
			ver_q   <= 1'b0;
			ttl_q   <= '0;
			sum_q   <= '0;
			port_q  <= 1'b0;
			loop_q  <= 1'b0;
			sent_q  <= 1'b1;
			rport_q <= 1'b0;
		end else if (step) begin
			wc_q    <= wc_n;
			ihl_q   <= ihl_n;
			dst_q   <= dst_n;
			smac_q  <= smac_n;
			ipv4_q  <= ipv4_n;
			ver_q   <= ver_n;
			ttl_q   <= ttl_n;
			sum_q   <= sum_n;
			port_q  <= port_e;
			loop_q  <= loop_e;
			sent_q  <= sent_n;
			rport_q <= rport_n;
		end
	end
endmodule

// File: design/ipv4_two_port_forwarder.sv
// ----------------------------------------------------------------------------
// ipv4_two_port_forwarder
// two-port ipv4 static router giving one verdict per ethernet frame
// ----------------------------------------------------------------------------
// The block takes one halfword per cycle, sustained, with no gaps needed
// between frames. Each accepted halfword is held in the input register,
// is then folded into the frame state by a single pass of compare and
// ones-complement add logic, and any verdict it causes lands in the result
// register, from which it is offered. Drop verdicts arrive with halfword 17
// or with the last halfword of a frame that ends early, a forward verdict
// with the last header halfword. The result register lets the next halfword
// be taken while a verdict waits; only a verdict left untaken stalls the input.
// Configuration writes take effect at once and belong in idle periods.
`include "ipv4_two_port_forwarder_macros.svh"

module ipv4_two_port_forwarder (
	input  logic                             clk,
	input  logic                             arst_n,
	ipv4f_in_if.sink                         frame,
	ipv4f_out_if.source                      result,
	input  logic                             cfg_we,
	input  logic [ipv4f_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipv4f_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ipv4f_pkg::*;

	cfg_t     cfg;
	in_item_t item_s1;
	logic     valid_s1;
	result_t  res_s2;
	logic     valid_s2;
	result_t  res;
	logic     emit;
	logic     advance;

	ipv4f_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	ipv4f_frame_proc u_proc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	// a halfword moves on when the result register is free or being drained
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign frame.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (frame.ready)
			valid_s1 <= frame.valid;
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			item_s1.half_word    <= frame.half_word;
			item_s1.frame_start  <= frame.frame_start;
			item_s1.frame_end    <= frame.frame_end;
			item_s1.arrival_port <= frame.arrival_port;
			item_s1.looped_back  <= frame.looped_back;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= emit;
		else if (result.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_s2 <= res;
	end

	assign result.valid          = valid_s2;
	assign result.verdict        = res_s2.verdict;
	assign result.out_port       = res_s2.out_port;
	assign result.new_ttl        = res_s2.new_ttl;
	assign result.new_checksum   = res_s2.new_checksum;
	assign result.new_dest_mac   = res_s2.new_dest_mac;
	assign result.new_source_mac = res_s2.new_source_mac;

	// checks
	`IPV4F_ASSERT(a_fwd_ttl_live, valid_s2 && res_s2.verdict == V_FORWARD |-> res_s2.new_ttl != 8'd0, "forward with expired ttl")
	`IPV4F_ASSERT(a_drop_zero, valid_s2 && res_s2.verdict != V_FORWARD |-> !res_s2.out_port && res_s2.new_ttl == 8'd0 && res_s2.new_dest_mac == '0, "drop verdict with payload")
	`IPV4F_ASSERT(a_hold_s1, valid_s1 && !advance |=> valid_s1 && $stable(item_s1), "stalled halfword lost")
	`IPV4F_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !valid_s1 && !valid_s2, "pipeline not empty in reset")
endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the two-port ipv4 forwarder
// ----------------------------------------------------------------------------
// Frames are built as halfword streams, many of them well formed for the
// route set loaded at the time, the rest broken in one chosen way or pure
// noise. A clocked driver feeds them into the block with random gaps, and a
// clocked monitor keeps a shadow of the frame state that predicts verdicts
// from the transferred halfwords and checks each verdict taken from the block
// against the oldest prediction. Route and MAC registers are reloaded between
// phases once the block has gone quiet, covering reset values and extremes.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv4f_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS   = 10;

	// ways of spoiling an otherwise good frame
	typedef enum int {
		FLAW_NONE,
		FLAW_SHORT,
		FLAW_OPT_END,
		FLAW_LOOPED,
		FLAW_ETHERTYPE,
		FLAW_OWN_SRC,
		FLAW_VERSION,
		FLAW_IHL,
		FLAW_DST,
		FLAW_SAME_PORT,
		FLAW_TTL,
		FLAW_NO_END,
		FLAW_TAIL
	} flaw_t;
	localparam int FLAW_KINDS = 13;

	typedef struct {
		int unsigned      n_words;
		logic [MAC_W-1:0] src_mac;
		logic [HW_W-1:0]  ethertype;
		logic [3:0]       version;
		logic [IHL_W-1:0] ihl;
		logic [TTL_W-1:0] ttl;
		logic [ADDR_W-1:0] dst_ip;
		bit               port;
		bit               looped;
		bit               no_end;
	} frame_plan_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ipv4f_in_if  frame_bus ();
	ipv4f_out_if verdict_bus ();

	ipv4_two_port_forwarder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_bus),
		.result    (verdict_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// stimulus and scoreboard storage
	in_item_t    pending[$];
	result_t     verdicts_due[$];
	cfg_t        route_cfg;
	int unsigned words_queued = 0;
	int unsigned fault_count = 0;
	bit          idle_on = 1'b1;
	bit          frame_fire = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;

	// shadow of the per-frame state
	logic [WC_W-1:0]   fs_count;
	logic [IHL_W-1:0]  fs_ihl;
	logic [ADDR_W-1:0] fs_dst;
	logic [MAC_W-1:0]  fs_src_mac;
	logic              fs_is_ipv4;
	logic              fs_ver_ok;
	logic [TTL_W-1:0]  fs_ttl;
	logic [HW_W-1:0]   fs_sum;
	logic              fs_port;
	logic              fs_looped;
	logic              fs_done;
	logic              fs_route_port;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// network mask, lengths from 32 upwards give a full mask
	function automatic logic [ADDR_W-1:0] net_mask(input logic [PFX_W-1:0] len);
		if (len >= 6'd32)
			return '1;
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	// end-around carry sum
	function automatic logic [HW_W-1:0] ones_add(input logic [HW_W-1:0] a,
		input logic [HW_W-1:0] b);
		logic [HW_W:0] wide;
		wide = a + b;
		return wide[HW_W-1:0] + wide[HW_W];
	endfunction

	// longest prefix of the two routes, route 0 on a tie
	function automatic bit route_lookup(input logic [ADDR_W-1:0] dst, output bit port);
		logic [ADDR_W-1:0] m0, m1;
		bit h0, h1;
		m0 = net_mask(route_cfg.r0_prefix);
		m1 = net_mask(route_cfg.r1_prefix);
		h0 = (dst & m0) == route_cfg.r0_network;
		h1 = (dst & m1) == route_cfg.r1_network;
		port = (h0 && h1) ? (m1 > m0) : h1;
		return h0 || h1;
	endfunction

	function automatic result_t make_verdict(input verdict_t v);
		result_t r;
		r = '0;
		r.verdict = v;
		if (v == V_FORWARD) begin
			r.out_port = fs_route_port;
			r.new_ttl = fs_ttl - 8'd1;
			r.new_checksum = ~fs_sum;
			r.new_dest_mac = fs_route_port ? route_cfg.r1_next_mac : route_cfg.r0_next_mac;
			r.new_source_mac = fs_route_port ? route_cfg.p1_own_mac : route_cfg.p0_own_mac;
		end
		fs_done = 1'b1;
		return r;
	endfunction

	function automatic void clear_frame_state();
		fs_count = '0;
		fs_ihl = '0;
		fs_dst = '0;
		fs_src_mac = '0;
		fs_is_ipv4 = 1'b0;
		fs_ver_ok = 1'b0;
		fs_ttl = '0;
		fs_sum = '0;
		fs_port = 1'b0;
		fs_looped = 1'b0;
		fs_route_port = 1'b0;
		fs_done = 1'b1;
	endfunction

	// fold one transferred halfword into the shadow state
	task automatic step_frame(input in_item_t it, output bit got, output result_t r);
		logic [WC_W-1:0] idx;
		logic [6:0]      last_idx;
		logic [HW_W-1:0] addend;
		bit              rp;
		got = 1'b0;
		r = '0;
		if (it.frame_start) begin
			clear_frame_state();
			fs_port = it.arrival_port;
			fs_looped = it.looped_back;
			fs_done = 1'b0;
		end
		if (fs_done)
			return;
		idx = fs_count;
		fs_count = fs_count + 1'b1;

		// capture of header fields
		if (idx >= IDX_SRC_FIRST && idx <= IDX_SRC_LAST)
			fs_src_mac = {fs_src_mac[31:0], it.half_word};
		else if (idx == IDX_ETHERTYPE)
			fs_is_ipv4 = it.half_word == ETHERTYPE_IPV4;
		else if (idx == IDX_VER_IHL) begin
			fs_ver_ok = it.half_word[15:12] == IP_VERSION4;
			fs_ihl = it.half_word[11:8];
		end else if (idx == IDX_TTL)
			fs_ttl = it.half_word[15:8];
		else if (idx == IDX_DST_HI || idx == IDX_DST_LO)
			fs_dst = {fs_dst[15:0], it.half_word};

		// header sum, ttl taken as already decremented, checksum left out
		last_idx = 7'(LAST_BASE + 2 * fs_ihl);
		if (idx >= IDX_VER_IHL && idx != IDX_CHECKSUM && (idx <= IDX_DST_LO || idx <= last_idx)) begin
			addend = (idx == IDX_TTL) ? it.half_word - TTL_STEP : it.half_word;
			fs_sum = ones_add(fs_sum, addend);
		end

		if (idx < IDX_DST_LO) begin
			if (it.frame_end) begin
				got = 1'b1;
				r = make_verdict(V_SHORT);
			end
		end else if (idx == IDX_DST_LO) begin
			// drop checks in priority order
			got = 1'b1;
			if (it.frame_end && fs_ihl > IHL_MIN)
				r = make_verdict(V_SHORT);
			else if (fs_looped)
				r = make_verdict(V_LOOPED);
			else if (!fs_is_ipv4)
				r = make_verdict(V_NOT_IPV4);
			else if (fs_src_mac == route_cfg.p0_own_mac || fs_src_mac == route_cfg.p1_own_mac)
				r = make_verdict(V_OWN_SOURCE);
			else if (!fs_ver_ok || fs_ihl < IHL_MIN)
				r = make_verdict(V_BAD_HEADER);
			else if (!route_lookup(fs_dst, rp))
				r = make_verdict(V_NO_ROUTE);
			else begin
				fs_route_port = rp;
				if (rp == fs_port)
					r = make_verdict(V_SAME_PORT);
				else if (fs_ttl <= TTL_MIN_FWD)
					r = make_verdict(V_TTL_EXPIRED);
				else if (fs_ihl == IHL_MIN)
					r = make_verdict(V_FORWARD);
				else
					got = 1'b0;
			end
		end else if (idx == last_idx) begin
			got = 1'b1;
			r = make_verdict(V_FORWARD);
		end else if (it.frame_end) begin
			got = 1'b1;
			r = make_verdict(V_SHORT);
		end
	endtask

	// stimulus building
	task automatic queue_raw(input logic [HW_W-1:0] hw, input bit first, input bit last,
		input bit port, input bit looped);
		in_item_t it;
		it.half_word = hw;
		it.frame_start = first;
		it.frame_end = last;
		it.arrival_port = port;
		it.looped_back = looped;
		pending.push_back(it);
		words_queued++;
	endtask

	task automatic queue_frame(input frame_plan_t p);
		logic [HW_W-1:0] w;
		logic [WC_W-1:0] pos;
		for (int i = 0; i < p.n_words; i++) begin
			w = 16'($urandom);
			pos = 6'(i);
			case (pos)
				IDX_SRC_FIRST:         w = p.src_mac[47:32];
				IDX_SRC_FIRST + 6'd1:  w = p.src_mac[31:16];
				IDX_SRC_LAST:          w = p.src_mac[15:0];
				IDX_ETHERTYPE:         w = p.ethertype;
				IDX_VER_IHL:           w = {p.version, p.ihl, w[7:0]};
				IDX_TTL:               w = {p.ttl, w[7:0]};
				IDX_DST_HI:            w = p.dst_ip[31:16];
				IDX_DST_LO:            w = p.dst_ip[15:0];
				default: ;
			endcase
			if (i >= 64)
				w = 16'($urandom);
			queue_raw(w, i == 0, (i == p.n_words - 1) && !p.no_end,
				(i == 0) ? p.port : 1'($urandom), (i == 0) ? p.looped : 1'($urandom));
		end
	endtask

	task automatic queue_noise(input int unsigned count);
		repeat (count)
			queue_raw(16'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
				1'($urandom), 1'($urandom));
	endtask

	// a frame that the current route set forwards, unless the chosen network has bits outside its mask
	function automatic frame_plan_t good_plan();
		frame_plan_t p;
		logic [ADDR_W-1:0] m, net;
		bit r, rp;
		r = 1'($urandom);
		m = net_mask(r ? route_cfg.r1_prefix : route_cfg.r0_prefix);
		net = r ? route_cfg.r1_network : route_cfg.r0_network;
		p.dst_ip = (net & m) | ($urandom & ~m);
		p.port = route_lookup(p.dst_ip, rp) ? !rp : 1'($urandom);
		p.src_mac = 48'({$urandom, $urandom});
		p.ethertype = ETHERTYPE_IPV4;
		p.version = IP_VERSION4;
		p.ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : IHL_MIN;
		p.ttl = 8'($urandom_range(2, 255));
		p.n_words = 7 + 2 * p.ihl + $urandom_range(0, 4);
		p.looped = 1'b0;
		p.no_end = 1'b0;
		return p;
	endfunction

	function automatic frame_plan_t apply_flaw(input frame_plan_t p, input flaw_t f);
		case (f)
			FLAW_SHORT:     p.n_words = $urandom_range(1, 16);
			FLAW_OPT_END: begin
				// ends inside the options, the 17th halfword included
				p.ihl = 4'($urandom_range(6, 15));
				p.n_words = $urandom_range(17, 6 + 2 * p.ihl);
			end
			FLAW_LOOPED:    p.looped = 1'b1;
			FLAW_ETHERTYPE: p.ethertype = 16'($urandom);
			FLAW_OWN_SRC:   p.src_mac = $urandom_range(0, 1) ? route_cfg.p1_own_mac
				: route_cfg.p0_own_mac;
			FLAW_VERSION:   p.version = 4'($urandom);
			FLAW_IHL:       p.ihl = 4'($urandom_range(0, 4));
			FLAW_DST:       p.dst_ip = $urandom;
			FLAW_SAME_PORT: p.port = !p.port;
			FLAW_TTL:       p.ttl = 8'($urandom_range(0, 1));
			FLAW_NO_END: begin
				p.no_end = 1'b1;
				p.n_words = $urandom_range(1, 24);
			end
			FLAW_TAIL:      p.n_words = p.n_words + $urandom_range(8, 40);
			default: ;
		endcase
		return p;
	endfunction

	task automatic run_traffic(input int unsigned words);
		int unsigned goal;
		flaw_t f;
		goal = words_queued + words;
		while (words_queued < goal) begin
			if ($urandom_range(0, 9) == 0)
				queue_noise($urandom_range(1, 8));
			else begin
				f = ($urandom_range(0, 1) == 0) ? FLAW_NONE
					: flaw_t'($urandom_range(1, FLAW_KINDS - 1));
				queue_frame(apply_flaw(good_plan(), f));
			end
		end
	endtask

	// register writes, called at a falling edge
	task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		@(negedge clk);
		// upper bits of narrow registers carry junk that must be dropped
		put_reg(CFG_R0_NETWORK, {junk[15:0], c.r0_network});
		put_reg(CFG_R0_PREFIX, {junk[57:16], c.r0_prefix});
		put_reg(CFG_R0_NEXT_MAC, c.r0_next_mac);
		put_reg(CFG_P0_OWN_MAC, c.p0_own_mac);
		put_reg(CFG_R1_NETWORK, {junk[63:48], c.r1_network});
		put_reg(CFG_R1_PREFIX, {junk[47:6], c.r1_prefix});
		put_reg(CFG_R1_NEXT_MAC, c.r1_next_mac);
		put_reg(CFG_P1_OWN_MAC, c.p1_own_mac);
		cfg_we <= 1'b0;
		route_cfg = c;
	endtask

	function automatic cfg_t random_config();
		cfg_t c;
		c.r0_prefix = 6'($urandom_range(0, 63));
		c.r0_network = $urandom & net_mask(c.r0_prefix);
		if ($urandom_range(0, 7) == 0)
			c.r0_network = $urandom;
		c.r1_prefix = 6'($urandom_range(0, 63));
		c.r1_network = $urandom & net_mask(c.r1_prefix);
		if ($urandom_range(0, 7) == 0)
			c.r1_network = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			c.r1_prefix = c.r0_prefix;
			c.r1_network = c.r0_network;
		end
		c.r0_next_mac = 48'({$urandom, $urandom});
		c.p0_own_mac = 48'({$urandom, $urandom});
		c.r1_next_mac = 48'({$urandom, $urandom});
		c.p1_own_mac = 48'({$urandom, $urandom});
		return c;
	endfunction

	// wait until every halfword is in and every verdict is out
	task automatic drain();
		do
			@(posedge clk);
		while (pending.size() != 0 || frame_bus.valid || verdicts_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// halfword driver
	always @(negedge clk) begin
		in_item_t nxt;
		if (!arst_n)
			frame_bus.valid <= 1'b0;
		else if (!frame_bus.valid || frame_fire) begin
			if (send_gap != 0) begin
				send_gap--;
				frame_bus.valid <= 1'b0;
			end else if (pending.size() != 0) begin
				nxt = pending.pop_front();
				frame_bus.valid <= 1'b1;
				frame_bus.half_word <= nxt.half_word;
				frame_bus.frame_start <= nxt.frame_start;
				frame_bus.frame_end <= nxt.frame_end;
				frame_bus.arrival_port <= nxt.arrival_port;
				frame_bus.looped_back <= nxt.looped_back;
				if (idle_on && $urandom_range(0, 15) == 0)
					send_gap = $urandom_range(1, 9);
			end else
				frame_bus.valid <= 1'b0;
		end
	end

	// verdict receiver with random stalls outside the full-rate closing stretch
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			verdict_bus.ready <= 1'b0;
		end else begin
			verdict_bus.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 9);
		end
	end

	// monitor: check verdicts, predict from transferred halfwords
	always @(posedge clk) begin
		result_t  seen, want, fresh;
		in_item_t taken;
		bit       hit;
		if (arst_n) begin
			if (verdict_bus.valid && verdict_bus.ready) begin
				seen.verdict = verdict_t'(verdict_bus.verdict);
				seen.out_port = verdict_bus.out_port;
				seen.new_ttl = verdict_bus.new_ttl;
				seen.new_checksum = verdict_bus.new_checksum;
				seen.new_dest_mac = verdict_bus.new_dest_mac;
				seen.new_source_mac = verdict_bus.new_source_mac;
				if (verdicts_due.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: unexpected verdict %0d", $realtime, seen.verdict);
				end else begin
					want = verdicts_due.pop_front();
					if (seen !== want) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS)
							$display("%0t: verdict mismatch exp %0d/%0d/%h/%h/%h/%h got %0d/%0d/%h/%h/%h/%h",
								$realtime, want.verdict, want.out_port, want.new_ttl,
								want.new_checksum, want.new_dest_mac, want.new_source_mac,
								seen.verdict, seen.out_port, seen.new_ttl,
								seen.new_checksum, seen.new_dest_mac, seen.new_source_mac);
					end
				end
			end
			if (frame_bus.valid && frame_bus.ready) begin
				taken.half_word = frame_bus.half_word;
				taken.frame_start = frame_bus.frame_start;
				taken.frame_end = frame_bus.frame_end;
				taken.arrival_port = frame_bus.arrival_port;
				taken.looped_back = frame_bus.looped_back;
				step_frame(taken, hit, fresh);
				if (hit)
					verdicts_due.push_back(fresh);
			end
		end
		frame_fire <= arst_n && frame_bus.valid && frame_bus.ready;
	end

	// watchdog on stalled traffic
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((frame_bus.valid && frame_bus.ready) || (verdict_bus.valid && verdict_bus.ready)
				|| (!frame_bus.valid && verdicts_due.size() == 0))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// sequence of phases
	initial begin : sequencer
		frame_plan_t p;
		cfg_t c;
		arst_n = 1'b1;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_bus.valid = 1'b0;
		frame_bus.half_word = '0;
		frame_bus.frame_start = 1'b0;
		frame_bus.frame_end = 1'b0;
		frame_bus.arrival_port = 1'b0;
		frame_bus.looped_back = 1'b0;
		verdict_bus.ready = 1'b0;
		clear_frame_state();
		route_cfg.r0_network = RST_R0_NETWORK;
		route_cfg.r0_prefix = RST_R0_PREFIX;
		route_cfg.r0_next_mac = RST_R0_NEXT_MAC;
		route_cfg.p0_own_mac = RST_P0_OWN_MAC;
		route_cfg.r1_network = RST_R1_NETWORK;
		route_cfg.r1_prefix = RST_R1_PREFIX;
		route_cfg.r1_next_mac = RST_R1_NEXT_MAC;
		route_cfg.p1_own_mac = RST_P1_OWN_MAC;
		// reset falls just after time zero so every register sees the edge
		#1 arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed cases on the reset route set
		queue_raw(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1);
		queue_raw(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
		for (int k = 0; k < FLAW_KINDS; k++)
			queue_frame(apply_flaw(good_plan(), flaw_t'(k)));
		p = good_plan();
		p.ttl = 8'hFF;
		p.ihl = 4'd15;
		p.n_words = 37;
		queue_frame(p);
		p = good_plan();
		p.ttl = 8'd2;
		queue_frame(p);
		p = good_plan();
		p.ttl = 8'd0;
		queue_frame(p);
		p = good_plan();
		p.n_words = 1;
		queue_frame(p);
		drain();

		// nested routes, longest prefix decides
		c.r0_network = 32'h0A00_0000;
		c.r0_prefix = 6'd8;
		c.r0_next_mac = 48'({$urandom, $urandom});
		c.p0_own_mac = 48'({$urandom, $urandom});
		c.r1_network = 32'h0A01_0000;
		c.r1_prefix = 6'd16;
		c.r1_next_mac = 48'({$urandom, $urandom});
		c.p1_own_mac = 48'({$urandom, $urandom});
		load_config(c);
		run_traffic(120);
		drain();

		// default route against a full-length host route, extreme macs
		c.r0_network = 32'h0;
		c.r0_prefix = 6'd0;
		c.r0_next_mac = '1;
		c.p0_own_mac = '1;
		c.r1_network = 32'hFFFF_FFFF;
		c.r1_prefix = 6'd32;
		c.r1_next_mac = '0;
		c.p1_own_mac = '0;
		load_config(c);
		run_traffic(100);
		drain();

		// identical routes, route 0 takes the tie
		c.r0_network = 32'hAC10_0000;
		c.r0_prefix = 6'd16;
		c.r0_next_mac = 48'({$urandom, $urandom});
		c.p0_own_mac = 48'({$urandom, $urandom});
		c.r1_network = 32'hAC10_0000;
		c.r1_prefix = 6'd16;
		c.r1_next_mac = 48'({$urandom, $urandom});
		c.p1_own_mac = 48'({$urandom, $urandom});
		load_config(c);
		run_traffic(100);
		drain();

		// random route sets
		repeat (3) begin
			load_config(random_config());
			run_traffic(80);
			drain();
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		load_config(random_config());
		run_traffic(100);
		drain();

		if (verdicts_due.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/ipv4f_pkg.sv
design/ipv4f_in_if.sv
design/ipv4f_out_if.sv
design/ipv4f_cfg_regs.sv
design/ipv4f_frame_proc.sv
design/ipv4_two_port_forwarder.sv
sim/tb_top.sv
